// ===== rtl/core/dks_pkg.sv =====
// shared types, permutation tables and helper functions for the des key schedule
`timescale 1ns / 1ps
package dks_pkg;

  localparam int KEY_W    = 64;
  localparam int HALF_W   = 28;
  localparam int JOIN_W   = 2 * HALF_W;
  localparam int SUBKEY_W = 48;
  localparam int ROUND_W  = 4;
  localparam int ROUNDS   = 16;

  typedef logic [JOIN_W-1:0]   halves_t;
  typedef logic [HALF_W-1:0]   half_t;
  typedef logic [SUBKEY_W-1:0] subkey_t;
  typedef logic [ROUND_W-1:0]  round_t;

  localparam round_t LAST_ROUND = round_t'(ROUNDS - 1);

  // key bit selection that drops parity, first listed key bit is the msb
  localparam logic [6:0] PC1_TAB [JOIN_W] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  // subkey compression, counted from the msb of the joined halves
  localparam logic [5:0] PC2_TAB [SUBKEY_W] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // rounds that rotate by two places, round 0 in bit 0
  localparam logic [ROUNDS-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

  // select 56 key bits, parity bits dropped
  function automatic halves_t pc1(input logic [KEY_W-1:0] key);
    halves_t sel;
    sel = '0;
    for (int i = 0; i < JOIN_W; i++) begin
      sel[JOIN_W-1-i] = key[6'(KEY_W - int'(PC1_TAB[i]))];
    end
    return sel;
  endfunction

  // compress joined halves into a round subkey
  function automatic subkey_t pc2(input halves_t joined);
    subkey_t sk;
    sk = '0;
    for (int j = 0; j < SUBKEY_W; j++) begin
      sk[SUBKEY_W-1-j] = joined[6'(JOIN_W - int'(PC2_TAB[j]))];
    end
    return sk;
  endfunction

  // rotate one half left by one or two places
  function automatic half_t rotl28(input half_t v, input logic two);
    half_t r;
    if (two) begin
      r = {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]};
    end else begin
      r = {v[HALF_W-2:0], v[HALF_W-1]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/dks_front.sv =====
// front end: takes key requests, selects the 56 key bits and holds the halves
`timescale 1ns / 1ps
module dks_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dks_pkg::KEY_W-1:0]     in_tdata,
  output logic                          push_valid,
  input  logic                          push_ready,
  output dks_pkg::halves_t              push_data
);
  import dks_pkg::*;

  logic    hold_valid_r;
  logic    hold_valid_nxt;
  halves_t hold_r;
  logic    accept;

  // holding register frees up whenever the queue takes its entry
  assign in_tready  = !hold_valid_r || push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = hold_valid_r;
  assign push_data  = hold_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (push_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // permuted key halves
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= pc1(in_tdata);
    end
  end

endmodule

// ===== rtl/core/dks_queue.sv =====
// two-entry queue of permuted keys between front end and round engine
`timescale 1ns / 1ps
module dks_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  dks_pkg::halves_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output dks_pkg::halves_t pop_data
);
  import dks_pkg::*;

  halves_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/dks_rounds.sv =====
// round engine: rotates halves one round per unstalled cycle, registers each subkey
`timescale 1ns / 1ps
module dks_rounds (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  dks_pkg::halves_t pop_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output dks_pkg::subkey_t out_subkey,
  output dks_pkg::round_t  out_round,
  output logic             out_last
);
  import dks_pkg::*;

  logic    busy_r;
  round_t  rnd_r;
  half_t   c_r;
  half_t   d_r;
  logic    out_valid_r;
  subkey_t out_subkey_r;
  round_t  out_round_r;
  logic    out_last_r;

  halves_t src;
  half_t   c_nxt;
  half_t   d_nxt;
  logic    slot_free;
  logic    adv;

  // start from the queue head or continue from the stored halves
  assign src       = busy_r ? {c_r, d_r} : pop_data;
  assign c_nxt     = rotl28(src[JOIN_W-1:HALF_W], ROT_TWO[rnd_r]);
  assign d_nxt     = rotl28(src[HALF_W-1:0], ROT_TWO[rnd_r]);
  assign slot_free = !out_valid_r || out_tready;
  assign adv       = slot_free && (busy_r || pop_valid);
  assign pop_ready = slot_free && !busy_r;

  assign out_tvalid = out_valid_r;
  assign out_subkey = out_subkey_r;
  assign out_round  = out_round_r;
  assign out_last   = out_last_r;

  // round sequencing and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        rnd_r  <= rnd_r + round_t'(1);
        busy_r <= (rnd_r != LAST_ROUND);
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // halves and output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      c_r          <= c_nxt;
      d_r          <= d_nxt;
      out_subkey_r <= pc2({c_nxt, d_nxt});
      out_round_r  <= rnd_r;
      out_last_r   <= (rnd_r == LAST_ROUND);
    end
  end

`ifndef SYNTHESIS
  // idle engine always waits at round zero
  a_idle_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> rnd_r == '0)
    else $error("round counter not zero while idle");

  // flagged subkey is the sixteenth
  a_last_is_round15: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_round_r == LAST_ROUND)
    else $error("last flag on wrong round");

  // no gap inside one key's run of subkeys
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tready && !out_last_r |=> out_valid_r)
    else $error("gap inside subkey run");

  // a new schedule begins with round zero
  a_start_round0: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> out_valid_r && out_round_r == '0)
    else $error("schedule did not start at round zero");
`endif

endmodule

// ===== rtl/core/des_key_schedule.sv =====
// Path: a taken key request is registered in the front-end holding register, then
// in the queue; each subkey is registered at the round engine output.
// Throughput: one subkey per cycle while the output is not stalled, from the round
// engine, which holds the rotating halves and issues one round per cycle.
// Reset: synchronous active-low rst_n clears queue, holding and output valid state.
`timescale 1ns / 1ps
module des_key_schedule (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dks_pkg::KEY_W-1:0]       in_tdata,   // [63:0] key
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dks_pkg::SUBKEY_W-1:0]    out_tdata,  // [47:0] subkey
  output logic [dks_pkg::ROUND_W-1:0]     out_tuser,  // [3:0] round_index
  output logic                            out_tlast   // last_round
);
  import dks_pkg::*;

  logic    push_valid;
  logic    push_ready;
  halves_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  halves_t pop_data;

  // key intake and parity-dropping bit selection
  dks_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  dks_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // round rotation and subkey compression
  dks_rounds u_rounds (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_subkey (out_tdata),
    .out_round  (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

// ===== tb/tb_des_key_schedule.sv =====
// self-checking des key schedule bench: fixed and random keys in, 16 subkeys out per key
`timescale 1ns / 1ps
module tb_des_key_schedule;
  import dks_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no request taken on either side
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_KEYS   = 330;

  // one expected subkey as it should leave the block
  typedef struct packed {
    round_t  round_idx;
    subkey_t subkey;
    logic    last;
  } subkey_rec_t;

  // key bit taken for each of the 56 selected bits, bit 1 is the key msb
  localparam logic [6:0] KEY_SELECT [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  // joined-halves bit taken for each subkey bit, bit 1 is the msb of c
  localparam logic [5:0] HALVES_SELECT [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam int ROUND_SHIFT [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [KEY_W-1:0]    in_tdata = '0;     // [63:0] key
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SUBKEY_W-1:0] out_tdata;         // [47:0] subkey
  logic [ROUND_W-1:0]  out_tuser;         // [3:0] round_index
  logic                out_tlast;         // last_round

  logic [KEY_W-1:0] pending_keys [$];
  subkey_rec_t      expected_subkeys [$];

  int in_gap = 0;
  int out_gap = 0;
  int keys_sent = 0;
  int subkeys_seen = 0;
  int quiet_cycles = 0;
  int fails = 0;

  des_key_schedule dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // expand one key into its 16 round subkeys and queue them in round order
  task automatic expand_key_schedule(input logic [KEY_W-1:0] key);
    logic [55:0] sel;
    logic [55:0] joined;
    logic [27:0] c_half;
    logic [27:0] d_half;
    subkey_t     sk;
    subkey_rec_t rec;
    for (int i = 0; i < 56; i++) begin
      sel[55-i] = key[64 - int'(KEY_SELECT[i])];
    end
    c_half = sel[55:28];
    d_half = sel[27:0];
    for (int r = 0; r < 16; r++) begin
      c_half = (c_half << ROUND_SHIFT[r]) | (c_half >> (28 - ROUND_SHIFT[r]));
      d_half = (d_half << ROUND_SHIFT[r]) | (d_half >> (28 - ROUND_SHIFT[r]));
      joined = {c_half, d_half};
      for (int j = 0; j < 48; j++) begin
        sk[47-j] = joined[56 - int'(HALVES_SELECT[j])];
      end
      rec.round_idx = round_t'(r);
      rec.subkey    = sk;
      rec.last      = (r == 15);
      expected_subkeys.push_back(rec);
    end
  endtask

  // wait cycles before the next request, none during burst stretches
  function automatic int draw_gap(input logic burst);
    return burst ? 0 : int'($urandom_range(0, 10));
  endfunction

  // random key: mostly dense, some sparse, some repeated-byte patterns
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    logic [7:0]       b;
    int               pick;
    pick = int'($urandom_range(0, 9));
    if (pick < 6) begin
      k = {$urandom, $urandom};
    end else if (pick < 8) begin
      k = ({$urandom, $urandom} & {$urandom, $urandom}) & {$urandom, $urandom};
    end else begin
      b = 8'($urandom);
      k = {8{b}};
    end
    return k;
  endfunction

  // key driver
  always @(posedge clk) begin : drive_keys
    int g;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (in_tvalid && in_tready) begin
      expand_key_schedule(in_tdata);
      keys_sent <= keys_sent + 1;
      g = draw_gap(((keys_sent / 40) % 3) == 2);
      if (g == 0 && pending_keys.size() > 1) begin
        in_tdata <= pending_keys[1];
      end else begin
        in_tvalid <= 1'b0;
        in_gap    <= (g > 0) ? g - 1 : 0;
      end
      void'(pending_keys.pop_front());
    end else if (!in_tvalid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_keys.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_keys[0];
      end
    end
  end

  // subkey monitor and checker
  always @(posedge clk) begin : check_subkeys
    int          g;
    subkey_rec_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else if (out_tvalid && out_tready) begin
      if (expected_subkeys.size() == 0) begin
        $error("unexpected subkey %h round %0d", out_tdata, out_tuser);
        fails++;
      end else begin
        want = expected_subkeys.pop_front();
        if (out_tuser !== want.round_idx) begin
          $error("round_index: expected %0d, got %0d", want.round_idx, out_tuser);
          fails++;
        end
        if (out_tdata !== want.subkey) begin
          $error("subkey: expected %h, got %h", want.subkey, out_tdata);
          fails++;
        end
        if (out_tlast !== want.last) begin
          $error("last_round: expected %b, got %b", want.last, out_tlast);
          fails++;
        end
      end
      subkeys_seen <= subkeys_seen + 1;
      g = draw_gap(((subkeys_seen / 500) % 3) == 1);
      if (g > 0) begin
        out_tready <= 1'b0;
        out_gap    <= g - 1;
      end
    end else if (!out_tready) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on stalled traffic
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    // extremes, alternating patterns, the weak keys, one semi-weak key and a fixed sample key
    pending_keys.push_back(64'h0000_0000_0000_0000);
    pending_keys.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_keys.push_back(64'h5555_5555_5555_5555);
    pending_keys.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_keys.push_back(64'h0101_0101_0101_0101);
    pending_keys.push_back(64'hFEFE_FEFE_FEFE_FEFE);
    pending_keys.push_back(64'h1F1F_1F1F_0E0E_0E0E);
    pending_keys.push_back(64'hE0E0_E0E0_F1F1_F1F1);
    pending_keys.push_back(64'h01FE_01FE_01FE_01FE);
    pending_keys.push_back(64'h1334_5779_9BBC_DFF1);
    // parity bits alone should give all-zero subkeys
    pending_keys.push_back(64'h0101_0101_0101_0101 ^ 64'h0);
    // lone bits: key msb, a parity bit, a bit landing in d, key lsb
    pending_keys.push_back(64'h8000_0000_0000_0000);
    pending_keys.push_back(64'h0100_0000_0000_0000);
    pending_keys.push_back(64'h0000_0000_0000_0002);
    pending_keys.push_back(64'h0000_0000_0000_0001);
    // upper key bytes only, lower key bytes only
    pending_keys.push_back(64'hFFFF_FFFF_0000_0000);
    pending_keys.push_back(64'h0000_0000_FFFF_FFFF);
    pending_keys.push_back(64'hFEFE_FEFE_0000_0000);
    pending_keys.push_back(64'h0000_0000_FEFE_FEFE);
    for (int i = 0; i < RAND_KEYS; i++) begin
      pending_keys.push_back(random_key());
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_keys.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_subkeys.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
